### design/dc_link_precharge_control_core_defines.svh
// Assertion macros for the DC-link precharge relay control block.
// Used by the checker module; no other dependencies.
`ifndef DC_LINK_PRECHARGE_CONTROL_CORE_DEFINES_SVH
`define DC_LINK_PRECHARGE_CONTROL_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DLPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlpc assertion failed");

// next-cycle implication, disabled during reset
`define DLPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlpc assertion failed");

`endif

### design/dlpc_pkg.sv
// Shared constants, codes and types for the DC-link precharge relay control.
// No dependencies.
`default_nettype none

package dlpc_pkg;

   localparam int VOLTAGE_BITS  = 24;
   localparam int SLOPE_SHIFT   = 11;
   localparam int SLOPE_BITS    = VOLTAGE_BITS + SLOPE_SHIFT;
   localparam int DWELL_BITS    = 32;
   localparam int ELAPSED_BITS  = 8;
   localparam int MODE_BITS     = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = (SLOPE_BITS > DWELL_BITS) ? SLOPE_BITS : DWELL_BITS;

   localparam logic [MODE_BITS-1:0] MODE_OFF  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_WAIT = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_ON   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TURN_ON       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TURN_OFF      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DWELL_TIMEOUT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOPE_LIMIT   = 3'd4;

   typedef struct packed {
      logic                           enable;
      logic signed [VOLTAGE_BITS-1:0] turn_on_voltage;
      logic signed [VOLTAGE_BITS-1:0] turn_off_voltage;
      logic [DWELL_BITS-1:0]          dwell_timeout_ms;
      logic [SLOPE_BITS-1:0]          slope_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [VOLTAGE_BITS-1:0] link_voltage;
      logic signed [VOLTAGE_BITS-1:0] filtered_voltage;
      logic [ELAPSED_BITS-1:0]        elapsed_ms;
      logic                           drive_running;
   } item_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]           mode;
      logic [MODE_BITS-1:0]           mode_seen_last;
      logic [DWELL_BITS-1:0]          dwell_counter;
      logic [SLOPE_BITS-1:0]          slope_value;
      logic signed [VOLTAGE_BITS-1:0] filtered_previous;
      logic                           relay;
      logic                           entered;
   } state_type;

endpackage

`default_nettype wire

### design/dc_link_precharge_control_core.sv
// DC-link precharge relay control: an accepted req goes from the input register into the
// state register (the result register) once the result side is free; rsp_valid then rises.
// Throughput one transaction per cycle; a result not taken holds the state register and
// the input register, so req_ready drops only while a result waits with rsp_ready low.
// Synchronous active-high reset: relay open, mode off, timers and slope cleared,
// enable set, thresholds zero. Depends on dlpc_pkg, dlpc_csr, dlpc_step.
`default_nettype none

module dc_link_precharge_control_core
   import dlpc_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [VOLTAGE_BITS-1:0] req_link_voltage,
   input  wire logic signed [VOLTAGE_BITS-1:0] req_filtered_voltage,
   input  wire logic [ELAPSED_BITS-1:0]        req_elapsed_ms,
   input  wire logic                           req_drive_running,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_relay_closed,
   output logic [MODE_BITS-1:0]                rsp_mode,
   output logic                                rsp_just_entered,
   input  wire logic                           csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]       csr_write_data
);

   cfg_type   cfg;
   item_type  item_ff, item_in;
   logic      in_valid_ff, in_valid_in;
   state_type state_ff, state_in;
   state_type state_nxt;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      advance;
   logic      req_accept;

   dlpc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   dlpc_step u_step (
      .cfg  (cfg),
      .item (item_ff),
      .st   (state_ff),
      .nxt  (state_nxt)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      item_in = item_ff;
      if (req_accept) begin
         item_in.link_voltage     = req_link_voltage;
         item_in.filtered_voltage = req_filtered_voltage;
         item_in.elapsed_ms       = req_elapsed_ms;
         item_in.drive_running    = req_drive_running;
      end
      in_valid_in  = req_accept || (in_valid_ff && !advance);
      state_in     = advance ? state_nxt : state_ff;
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{mode: MODE_OFF, mode_seen_last: MODE_OFF, default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_relay_closed = state_ff.relay;
   assign rsp_mode         = state_ff.mode;
   assign rsp_just_entered = state_ff.entered;

endmodule

`default_nettype wire

### design/dlpc_csr.sv
// Configuration register file of the precharge relay control.
// Depends on dlpc_pkg.
`default_nettype none

module dlpc_csr
   import dlpc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output cfg_type                        cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE:        cfg_in.enable = csr_write_data[0];
            CSR_TURN_ON:       cfg_in.turn_on_voltage = $signed(csr_write_data[VOLTAGE_BITS-1:0]);
            CSR_TURN_OFF:      cfg_in.turn_off_voltage = $signed(csr_write_data[VOLTAGE_BITS-1:0]);
            CSR_DWELL_TIMEOUT: cfg_in.dwell_timeout_ms = csr_write_data[DWELL_BITS-1:0];
            CSR_SLOPE_LIMIT:   cfg_in.slope_limit = csr_write_data[SLOPE_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable           <= 1'b1;
         cfg_ff.turn_on_voltage  <= '0;
         cfg_ff.turn_off_voltage <= '0;
         cfg_ff.dwell_timeout_ms <= '0;
         cfg_ff.slope_limit      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### design/dlpc_step.sv
// Next-state logic of the precharge relay state machine for one transaction.
// Depends on dlpc_pkg.
`default_nettype none

module dlpc_step
   import dlpc_pkg::*;
(
   input  wire cfg_type   cfg,
   input  wire item_type  item,
   input  wire state_type st,
   output state_type      nxt
);

   logic                          ent;
   logic [DWELL_BITS-1:0]         dwell_base;
   logic [DWELL_BITS:0]           dwell_sum;
   logic [DWELL_BITS-1:0]         dwell_sat;
   logic signed [VOLTAGE_BITS:0]  diff;
   logic [VOLTAGE_BITS:0]         mag;
   logic [SLOPE_BITS-1:0]         slope_new;
   logic                          above_on;
   logic                          below_off;
   logic                          above_off;

   always_comb begin
      ent        = (st.mode_seen_last != st.mode);
      dwell_base = ent ? '0 : st.dwell_counter;
      dwell_sum  = {1'b0, dwell_base} + {{(DWELL_BITS + 1 - ELAPSED_BITS){1'b0}}, item.elapsed_ms};
      dwell_sat  = dwell_sum[DWELL_BITS] ? '1 : dwell_sum[DWELL_BITS-1:0];

      diff = {item.filtered_voltage[VOLTAGE_BITS-1], item.filtered_voltage}
           - {st.filtered_previous[VOLTAGE_BITS-1], st.filtered_previous};
      mag  = diff[VOLTAGE_BITS] ? (~diff + 1'b1) : diff;
      slope_new = (item.elapsed_ms != '0)
                ? (SLOPE_BITS'(mag[VOLTAGE_BITS-1:0]) << SLOPE_SHIFT)
                : st.slope_value;

      above_on  = $signed(item.link_voltage) > $signed(cfg.turn_on_voltage);
      below_off = $signed(item.link_voltage) < $signed(cfg.turn_off_voltage);
      above_off = $signed(item.link_voltage) > $signed(cfg.turn_off_voltage);

      nxt = st;
      if (cfg.enable) begin
         nxt.mode_seen_last = st.mode;
         nxt.entered        = ent;
         unique case (st.mode)
            MODE_OFF: begin
               nxt.relay = 1'b0;
               if (above_on) nxt.mode = MODE_WAIT;
            end
            MODE_WAIT: begin
               nxt.relay         = 1'b0;
               nxt.dwell_counter = dwell_sat;
               nxt.slope_value   = slope_new;
               if (item.elapsed_ms != '0) nxt.filtered_previous = item.filtered_voltage;
               if (below_off) nxt.mode = MODE_OFF;
               if (dwell_sat >= cfg.dwell_timeout_ms && slope_new < cfg.slope_limit
                   && above_off) begin
                  nxt.mode          = MODE_ON;
                  nxt.dwell_counter = '0;
               end
            end
            MODE_ON: begin
               nxt.relay = 1'b1;
               if (below_off && !item.drive_running) nxt.mode = MODE_OFF;
            end
            default: begin
               nxt.mode = st.mode;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### design/dlpc_checker.sv
// Port-level checker for dc_link_precharge_control_core, bound to the top level.
// Depends on dlpc_pkg and dc_link_precharge_control_core_defines.svh.
`default_nettype none
`include "dc_link_precharge_control_core_defines.svh"

module dlpc_checker
   import dlpc_pkg::*;
(
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_relay_closed,
   input wire logic [MODE_BITS-1:0]           rsp_mode
);

   // relay is never closed while waiting
   `DLPC_ASSERT_NOW(a_wait_relay_open, clock, reset, rsp_valid && rsp_mode == MODE_WAIT, !rsp_relay_closed)

   // input side stalls only when a result is pending and not taken
   `DLPC_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // no result right after reset
   `DLPC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // pending transaction holds its payload
   `DLPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mode) && $stable(rsp_relay_closed))

endmodule

bind dc_link_precharge_control_core dlpc_checker u_dlpc_checker (.*);

`default_nettype wire
